// ----- hdl/ctds_pkg.sv -----
// Package for the character translate/delete/squeeze filter.
// Holds widths, item and register codes, controller state, command and status structs.
// No dependencies; imported by every module of the block.
`default_nettype none
package ctds_pkg;

  localparam int CP_W = 21;
  localparam int FUNC_W = 2;
  localparam int ENTRY_IDX_W = 8;
  localparam int LEN_W = 9;
  localparam int CLS_W = 4;
  localparam int CMAP_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 9;
  localparam int DEFAULT_SET_DEPTH = 256;

  localparam logic [CLS_W-1:0] CLASS_LOWER = 4'b0001;
  localparam logic [CLS_W-1:0] CLASS_UPPER = 4'b0010;
  localparam logic [CLS_W-1:0] CLASS_ALPHA = 4'b0100;
  localparam logic [CLS_W-1:0] CLASS_ALNUM = 4'b1000;

  localparam logic [CMAP_W-1:0] CMAP_UPPER = 2'd1;
  localparam logic [CMAP_W-1:0] CMAP_LOWER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COMPLEMENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELETE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SET1_CLASS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SET2_CLASS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SET1_LEN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SET2_LEN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CASE_MAP = 3'd7;

  localparam logic [CP_W-1:0] CASE_DELTA = 21'd32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD1   = 2'd0,
    FUNC_LOAD2   = 2'd1,
    FUNC_PROC    = 2'd2,
    FUNC_RESTART = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN1,
    ST_DECIDE,
    ST_XTAKE,
    ST_SQCHK,
    ST_SQSCAN,
    ST_SQDEC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic start_scan;
    logic scan_sel;
    logic apply;
    logic take_set2;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic drop_del;
    logic xlate_list;
    logic sq_cand;
    logic sq_sel;
    logic sq_member;
    logic out_free;
  } sts_t;

  function automatic logic class_hit(input logic [CLS_W-1:0] cls, input logic [CP_W-1:0] c);
    logic lo;
    logic up;
    logic dg;
    lo = (c >= 21'd97) && (c <= 21'd122);
    up = (c >= 21'd65) && (c <= 21'd90);
    dg = (c >= 21'd48) && (c <= 21'd57);
    return ((|(cls & CLASS_LOWER)) && lo) || ((|(cls & CLASS_UPPER)) && up) ||
           ((|(cls & CLASS_ALPHA)) && (lo || up)) ||
           ((|(cls & CLASS_ALNUM)) && (lo || up || dg));
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ctds_ctrl.sv -----
// Controller state machine of the filter: sequences scans, translation and emit.
// Depends on ctds_pkg; drives ctds_dp through cmd_t and reads sts_t.
`default_nettype none
module ctds_ctrl import ctds_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire func_t in_func,
  output logic       in_ready,
  input  wire sts_t  sts,
  output cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_func == FUNC_PROC) begin
            cmd.start_scan = 1'b1;
            state_nxt = ST_SCAN1;
          end
        end
      end
      ST_SCAN1: begin
        if (sts.scan_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.drop_del) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.apply = 1'b1;
          state_nxt = sts.xlate_list ? ST_XTAKE : ST_SQCHK;
        end
      end
      ST_XTAKE: begin
        cmd.take_set2 = 1'b1;
        state_nxt = ST_SQCHK;
      end
      ST_SQCHK: begin
        if (sts.sq_cand) begin
          cmd.start_scan = 1'b1;
          cmd.scan_sel = sts.sq_sel;
          state_nxt = ST_SQSCAN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SQSCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_SQDEC;
        end
      end
      ST_SQDEC: begin
        state_nxt = sts.sq_member ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/ctds_dp.sv -----
// Datapath of the filter: set memories, configuration registers, scan unit and
// result register. Depends on ctds_pkg; commanded by ctds_ctrl.
`default_nettype none
module ctds_dp import ctds_pkg::*; #(
  parameter int SET_DEPTH = DEFAULT_SET_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  input  wire func_t                  in_func,
  input  wire logic [ENTRY_IDX_W-1:0] in_entry_index,
  input  wire logic [CP_W-1:0]        in_codepoint,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [CP_W-1:0]             out_codepoint
);

  localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CNT_W = $clog2(SET_DEPTH + 1);

  logic [CP_W-1:0] set1_mem [SET_DEPTH];
  logic [CP_W-1:0] set2_mem [SET_DEPTH];

  logic              complement_r;
  logic              delete_r;
  logic              squeeze_r;
  logic [CLS_W-1:0]  cls1_r;
  logic [CLS_W-1:0]  cls2_r;
  logic [LEN_W-1:0]  len1_r;
  logic [LEN_W-1:0]  len2_r;
  logic [CMAP_W-1:0] cmap_r;

  logic [CP_W-1:0]  cur_r;
  logic [CP_W-1:0]  last_r;
  logic             flag_r;
  logic             out_valid_r;
  logic [CP_W-1:0]  out_r;
  logic [CP_W-1:0]  rd1_r;
  logic [CP_W-1:0]  rd2_r;

  logic             busy_r;
  logic             sel_r;
  logic [CNT_W-1:0] issue_r;
  logic             cmp_v_r;
  logic [IDX_W-1:0] cmp_pos_r;
  logic             found_r;
  logic [IDX_W-1:0] pos_r;

  logic [CNT_W-1:0] n1;
  logic [CNT_W-1:0] n2;
  logic [CNT_W-1:0] n2m1;
  logic [CNT_W-1:0] n_scan;
  logic             issue_ok;
  logic [CP_W-1:0]  rdata;
  logic             hit;
  logic             done;
  logic             wr_ok;
  logic [IDX_W-1:0] wr_addr;
  logic             rd1_en;
  logic             rd2_en;
  logic [IDX_W-1:0] rd2_addr;
  logic [IDX_W-1:0] xidx;
  logic             hit1;
  logic             hit2;
  logic             in1;
  logic             case_mode;
  logic             sq_use1;
  logic [CP_W-1:0]  mapped;

  always_comb begin
    n1 = (32'(len1_r) > 32'(SET_DEPTH)) ? CNT_W'(SET_DEPTH) : CNT_W'(len1_r);
    n2 = (32'(len2_r) > 32'(SET_DEPTH)) ? CNT_W'(SET_DEPTH) : CNT_W'(len2_r);
    n2m1 = n2 - CNT_W'(1);
    n_scan = sel_r ? n2 : n1;
    issue_ok = busy_r && (issue_r < n_scan);
    rdata = sel_r ? rd2_r : rd1_r;
    hit = busy_r && cmp_v_r && (rdata == cur_r);
    done = busy_r && (hit || (!cmp_v_r && !issue_ok));
    wr_ok = 32'(in_entry_index) < 32'(SET_DEPTH);
    wr_addr = IDX_W'(in_entry_index);
    hit1 = (cls1_r != '0) && class_hit(cls1_r, cur_r);
    hit2 = (cls2_r != '0) && class_hit(cls2_r, cur_r);
    in1 = complement_r ^ (hit1 || found_r);
    case_mode = (cmap_r == CMAP_UPPER) || (cmap_r == CMAP_LOWER);
    sq_use1 = (n2 == '0) && (cls2_r == '0);
    xidx = (complement_r || !found_r || (CNT_W'(pos_r) >= n2)) ? n2m1[IDX_W-1:0] : pos_r;
    rd1_en = issue_ok && !sel_r;
    rd2_en = (issue_ok && sel_r) || (cmd.apply && in1 && !case_mode && (n2 != '0));
    rd2_addr = (issue_ok && sel_r) ? issue_r[IDX_W-1:0] : xidx;
    mapped = cur_r;
    if ((cmap_r == CMAP_UPPER) && (cur_r >= 21'd97) && (cur_r <= 21'd122)) begin
      mapped = cur_r - CASE_DELTA;
    end else if ((cmap_r == CMAP_LOWER) && (cur_r >= 21'd65) && (cur_r <= 21'd90)) begin
      mapped = cur_r + CASE_DELTA;
    end
    sts.scan_done = done;
    sts.drop_del = in1 && delete_r;
    sts.xlate_list = in1 && !case_mode && (n2 != '0);
    sts.sq_cand = squeeze_r && flag_r && (cur_r == last_r);
    sts.sq_sel = !sq_use1;
    sts.sq_member = sq_use1 ? in1 : (hit2 || found_r);
    sts.out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_func == FUNC_LOAD1) && wr_ok) begin
      set1_mem[wr_addr] <= in_codepoint;
    end
    if (rd1_en) begin
      rd1_r <= set1_mem[issue_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_func == FUNC_LOAD2) && wr_ok) begin
      set2_mem[wr_addr] <= in_codepoint;
    end
    if (rd2_en) begin
      rd2_r <= set2_mem[rd2_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      complement_r <= 1'b0;
      delete_r <= 1'b0;
      squeeze_r <= 1'b0;
      cls1_r <= '0;
      cls2_r <= '0;
      len1_r <= '0;
      len2_r <= '0;
      cmap_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COMPLEMENT: complement_r <= cfg_data[0];
        REG_DELETE:     delete_r <= cfg_data[0];
        REG_SQUEEZE:    squeeze_r <= cfg_data[0];
        REG_SET1_CLASS: cls1_r <= cfg_data[CLS_W-1:0];
        REG_SET2_CLASS: cls2_r <= cfg_data[CLS_W-1:0];
        REG_SET1_LEN:   len1_r <= cfg_data[LEN_W-1:0];
        REG_SET2_LEN:   len2_r <= cfg_data[LEN_W-1:0];
        REG_CASE_MAP:   cmap_r <= cfg_data[CMAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cmp_v_r <= 1'b0;
      sel_r <= 1'b0;
      issue_r <= '0;
    end else if (cmd.start_scan) begin
      busy_r <= 1'b1;
      sel_r <= cmd.scan_sel;
      issue_r <= '0;
      cmp_v_r <= 1'b0;
    end else if (busy_r) begin
      if (done) begin
        busy_r <= 1'b0;
        cmp_v_r <= 1'b0;
      end else begin
        cmp_v_r <= issue_ok;
        if (issue_ok) begin
          issue_r <= issue_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_ok) begin
      cmp_pos_r <= issue_r[IDX_W-1:0];
    end
    if (done) begin
      found_r <= hit;
      pos_r <= cmp_pos_r;
    end
    if (cmd.accept) begin
      cur_r <= in_codepoint;
    end else if (cmd.apply && in1 && case_mode) begin
      cur_r <= mapped;
    end else if (cmd.take_set2) begin
      cur_r <= rd2_r;
    end
    if (cmd.emit) begin
      out_r <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      flag_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept && (in_func == FUNC_RESTART)) begin
        flag_r <= 1'b0;
      end else if (cmd.emit) begin
        flag_r <= 1'b1;
        last_r <= cur_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_codepoint = out_r;

endmodule
`default_nettype wire

// ----- hdl/char_translate_delete_squeeze_top.sv -----
// Top level of the character translate/delete/squeeze filter.
// Depends on ctds_pkg, ctds_ctrl and ctds_dp.
//
// The input channel carries items: load a set1 entry, load a set2 entry,
// process a codepoint, or restart the stream. Loads and restarts give no
// beat. A process item gives zero or one output beat. A process item scans
// set1 one entry per cycle through the memory read port, then decides; a
// deleted item ends there. List translation adds a state that takes the entry
// read from set2, and a further state checks for a squeeze candidate. A
// candidate scans set2, or set1 when set2 has no entries and no class bits,
// then decides in a further state; an emitted beat takes a last state.
// One item is worked on at a time. The output register holds a beat until it
// is taken, and the next item is accepted meanwhile; a finished result waits
// only for the output register to be free. Reset clears the configuration
// registers, the last emitted codepoint and the emitted flag; set contents are
// undefined until loaded. Configuration must be written only while the block
// is idle; the block itself does not enforce this.
`default_nettype none
module char_translate_delete_squeeze_top import ctds_pkg::*; #(
  parameter int SET_DEPTH = DEFAULT_SET_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [FUNC_W-1:0]      in_func,
  input  wire logic [ENTRY_IDX_W-1:0] in_entry_index,
  input  wire logic [CP_W-1:0]        in_codepoint,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [CP_W-1:0]             out_codepoint,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t  cmd;
  sts_t  sts;
  func_t func;

  assign func = func_t'(in_func);

  ctds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ctds_dp #(
    .SET_DEPTH (SET_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (func),
    .in_entry_index (in_entry_index),
    .in_codepoint   (in_codepoint),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_codepoint  (out_codepoint)
  );

endmodule
`default_nettype wire

// ----- hdl/ctds_chk.sv -----
// Port-level checker of the filter, bound to the top level.
// Depends on ctds_pkg and char_translate_delete_squeeze_top.
`default_nettype none
module ctds_chk import ctds_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic [FUNC_W-1:0]      in_func,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [CP_W-1:0]        out_codepoint
);

  logic proc_acc;
  logic other_acc;

  assign proc_acc = in_valid && in_ready && (in_func == FUNC_PROC);
  assign other_acc = in_valid && in_ready && (in_func != FUNC_PROC);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_codepoint))
    else $error("output beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    other_acc && !out_valid |=> !out_valid)
    else $error("load or restart item produced a beat");

  a_busy_after_proc: assert property (@(posedge clk) disable iff (!rst_n)
    proc_acc |=> !in_ready)
    else $error("input ready right after a process item");

endmodule

bind char_translate_delete_squeeze_top ctds_chk u_ctds_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_func       (in_func),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_codepoint (out_codepoint)
);
`default_nettype wire

// ----- sim/ctds_checker.sv -----
// Checker for the character translate/delete/squeeze filter: watches the input,
// output and configuration ports, predicts each output beat and compares it.
// Depends on ctds_pkg for widths, item codes and register indexes.
module ctds_checker import ctds_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_ready,
  input  wire logic [FUNC_W-1:0]      in_func,
  input  wire logic [ENTRY_IDX_W-1:0] in_entry_index,
  input  wire logic [CP_W-1:0]        in_codepoint,
  input  wire logic                   out_valid,
  input  wire logic                   out_ready,
  input  wire logic [CP_W-1:0]        out_codepoint,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output int                          fail_count,
  output int                          pending,
  output int                          beats_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEFAULT_SET_DEPTH;

  logic [CP_W-1:0]   set1_mem [DEPTH];
  logic [CP_W-1:0]   set2_mem [DEPTH];
  logic [CP_W-1:0]   last_cp;
  logic              emitted;
  logic              complement_r;
  logic              delete_r;
  logic              squeeze_r;
  logic [CLS_W-1:0]  cls1_r;
  logic [CLS_W-1:0]  cls2_r;
  logic [LEN_W-1:0]  len1_r;
  logic [LEN_W-1:0]  len2_r;
  logic [CMAP_W-1:0] cmap_r;
  logic [CP_W-1:0]   expected_cps [$];

  function automatic int clip(input logic [LEN_W-1:0] n);
    return (n > DEPTH) ? DEPTH : int'(n);
  endfunction

  function automatic bit is_ascii_class(input logic [CLS_W-1:0] cls, input logic [CP_W-1:0] c);
    bit lo;
    bit up;
    bit dg;
    lo = (c >= "a") && (c <= "z");
    up = (c >= "A") && (c <= "Z");
    dg = (c >= "0") && (c <= "9");
    return (cls[0] && lo) || (cls[1] && up) || (cls[2] && (lo || up)) ||
           (cls[3] && (lo || up || dg));
  endfunction

  function automatic int find_in_set(input bit second, input logic [CP_W-1:0] c);
    int n;
    n = clip(second ? len2_r : len1_r);
    for (int i = 0; i < n; i++) begin
      if ((second ? set2_mem[i] : set1_mem[i]) == c) return i;
    end
    return -1;
  endfunction

  function automatic bit selected_by_set1(input logic [CP_W-1:0] c);
    bit m;
    m = (cls1_r != 0 && is_ascii_class(cls1_r, c)) || (find_in_set(1'b0, c) >= 0);
    return complement_r ? !m : m;
  endfunction

  function automatic logic [CP_W-1:0] mapped_cp(input logic [CP_W-1:0] c);
    int n2;
    int pos;
    if (cmap_r == CMAP_UPPER) return (c >= "a" && c <= "z") ? c - CASE_DELTA : c;
    if (cmap_r == CMAP_LOWER) return (c >= "A" && c <= "Z") ? c + CASE_DELTA : c;
    n2 = clip(len2_r);
    if (n2 == 0) return c;
    pos = complement_r ? -1 : find_in_set(1'b0, c);
    if (pos < 0 || pos >= n2) return set2_mem[n2-1];
    return set2_mem[pos];
  endfunction

  function automatic bit squeezes(input logic [CP_W-1:0] c);
    if (clip(len2_r) == 0 && cls2_r == 0) return selected_by_set1(c);
    return (cls2_r != 0 && is_ascii_class(cls2_r, c)) || (find_in_set(1'b1, c) >= 0);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic filter_codepoint(input logic [CP_W-1:0] cp_in);
    logic [CP_W-1:0] c;
    c = cp_in;
    if (selected_by_set1(c)) begin
      if (delete_r) return;
      c = mapped_cp(c);
    end
    if (squeeze_r && emitted && c == last_cp && squeezes(c)) return;
    last_cp = c;
    emitted = 1'b1;
    expected_cps.push_back(c);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count = 0;
      beats_seen = 0;
      last_cp = '0;
      emitted = 1'b0;
      {complement_r, delete_r, squeeze_r} = '0;
      {cls1_r, cls2_r, len1_r, len2_r, cmap_r} = '0;
      expected_cps.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COMPLEMENT: complement_r = cfg_data[0];
          REG_DELETE:     delete_r = cfg_data[0];
          REG_SQUEEZE:    squeeze_r = cfg_data[0];
          REG_SET1_CLASS: cls1_r = cfg_data[CLS_W-1:0];
          REG_SET2_CLASS: cls2_r = cfg_data[CLS_W-1:0];
          REG_SET1_LEN:   len1_r = cfg_data[LEN_W-1:0];
          REG_SET2_LEN:   len2_r = cfg_data[LEN_W-1:0];
          REG_CASE_MAP:   cmap_r = cfg_data[CMAP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        beats_seen++;
        if (expected_cps.size() == 0) begin
          report_mismatch($sformatf("unexpected beat %h", out_codepoint));
        end else begin
          if (out_codepoint !== expected_cps[0])
            report_mismatch($sformatf("out_codepoint %h, expected %h",
                                      out_codepoint, expected_cps[0]));
          void'(expected_cps.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        case (in_func)
          FUNC_LOAD1:   set1_mem[in_entry_index] = in_codepoint;
          FUNC_LOAD2:   set2_mem[in_entry_index] = in_codepoint;
          FUNC_RESTART: emitted = 1'b0;
          default:      filter_codepoint(in_codepoint);
        endcase
      end
    end
    pending = expected_cps.size();
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the character translate/delete/squeeze filter: resets, loads
// both sets, drives directed and random items and configurations, gives the verdict.
// Depends on ctds_pkg, char_translate_delete_squeeze_top and ctds_checker.
module tb import ctds_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 600;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    bit complement;
    bit del;
    bit squeeze;
    logic [CLS_W-1:0] cls1;
    logic [CLS_W-1:0] cls2;
    logic [LEN_W-1:0] len1;
    logic [LEN_W-1:0] len2;
    logic [CMAP_W-1:0] cmap;
  } filter_cfg_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  func_t in_func;
  logic [ENTRY_IDX_W-1:0] in_entry_index;
  logic [CP_W-1:0] in_codepoint;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CP_W-1:0] out_codepoint;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count;
  int pending;
  int beats_seen;

  bit no_idle;
  int items_sent;
  int cfg_phases;
  int quiet_cycles = 0;
  logic [CP_W-1:0] set1_copy [DEFAULT_SET_DEPTH];
  logic [CP_W-1:0] set2_copy [DEFAULT_SET_DEPTH];
  logic [CP_W-1:0] prev_cp;
  filter_cfg_t cur;

  char_translate_delete_squeeze_top u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_entry_index, .in_codepoint,
    .out_valid, .out_ready, .out_codepoint, .cfg_we, .cfg_index, .cfg_data
  );

  ctds_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_entry_index, .in_codepoint,
    .out_valid, .out_ready, .out_codepoint, .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending, .beats_seen
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 29);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input func_t f, input int idx, input logic [CP_W-1:0] cp);
    if (!no_idle && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 29);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_entry_index <= idx[ENTRY_IDX_W-1:0];
    in_codepoint <= cp;
    do @(posedge clk); while (!in_ready);
    if (f == FUNC_LOAD1) set1_copy[idx] = cp;
    if (f == FUNC_LOAD2) set2_copy[idx] = cp;
    if (f == FUNC_PROC) prev_cp = cp;
    items_sent++;
  endtask

  task automatic drain(input bit hold);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    if (hold) repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic apply_cfg(input filter_cfg_t c);
    logic [CFG_DATA_W-1:0] vals [8];
    drain(1'b1);
    vals = '{CFG_DATA_W'(c.complement), CFG_DATA_W'(c.del), CFG_DATA_W'(c.squeeze),
             CFG_DATA_W'(c.cls1), CFG_DATA_W'(c.cls2), CFG_DATA_W'(c.len1),
             CFG_DATA_W'(c.len2), CFG_DATA_W'(c.cmap)};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur = c;
    cfg_phases++;
  endtask

  function automatic logic [CP_W-1:0] pick_entry();
    case ($urandom_range(0, 3))
      0, 1: return CP_W'($urandom_range(32, 126));
      2:    return CP_W'($urandom_range(0, 255));
      default: return CP_W'($urandom);
    endcase
  endfunction

  function automatic logic [CP_W-1:0] pick_codepoint();
    int n1;
    n1 = (cur.len1 == 0) ? 8 : int'(cur.len1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return set1_copy[$urandom_range(0, n1 - 1)];
      4:    return set2_copy[$urandom_range(0, 7)];
      5, 6: return CP_W'($urandom_range(48, 122));
      7:    return prev_cp;
      default: return CP_W'($urandom);
    endcase
  endfunction

  function automatic filter_cfg_t random_cfg();
    filter_cfg_t c;
    c.complement = ($urandom_range(0, 3) == 0);
    c.del = ($urandom_range(0, 3) == 0);
    c.squeeze = 1'($urandom_range(0, 1));
    c.cls1 = $urandom_range(0, 1) ? CLS_W'($urandom) : '0;
    c.cls2 = $urandom_range(0, 1) ? CLS_W'($urandom) : '0;
    if ($urandom_range(0, 7) == 0) begin
      c.len1 = $urandom_range(0, 1) ? LEN_W'(DEFAULT_SET_DEPTH)
                                    : LEN_W'($urandom_range(0, DEFAULT_SET_DEPTH));
      c.len2 = LEN_W'($urandom_range(0, DEFAULT_SET_DEPTH));
    end else begin
      c.len1 = LEN_W'($urandom_range(0, 8));
      c.len2 = LEN_W'($urandom_range(0, 8));
    end
    c.cmap = ($urandom_range(0, 4) < 3) ? '0 : CMAP_W'($urandom_range(1, 2));
    return c;
  endfunction

  initial begin
    filter_cfg_t c;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= FUNC_LOAD1;
    in_entry_index <= '0;
    in_codepoint <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    no_idle = 1'b0;
    items_sent = 0;
    cfg_phases = 0;
    prev_cp = '0;
    cur = '{0, 0, 0, '0, '0, '0, '0, '0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(FUNC_PROC, 0, '0);
    send(FUNC_PROC, 0, '1);
    send(FUNC_PROC, 0, 21'h10FFFF);
    for (int i = 0; i < DEFAULT_SET_DEPTH; i++) begin
      send(FUNC_LOAD1, i, (i == 255) ? '1 : pick_entry());
      send(FUNC_LOAD2, i, (i == 0) ? '0 : pick_entry());
    end

    apply_cfg('{0, 0, 1, '0, '0, 9'd256, 9'd256, '0});
    send(FUNC_PROC, 0, set1_copy[0]);
    send(FUNC_PROC, 0, set1_copy[255]);
    send(FUNC_PROC, 0, set1_copy[255]);
    send(FUNC_RESTART, 0, '0);
    send(FUNC_PROC, 0, set1_copy[255]);
    apply_cfg('{1, 0, 1, '0, '0, 9'd4, 9'd4, '0});
    send(FUNC_PROC, 0, CP_W'("q"));
    send(FUNC_PROC, 0, '1);
    apply_cfg('{0, 0, 1, 4'hF, '0, 9'd2, 9'd0, '0});
    send(FUNC_PROC, 0, CP_W'("M"));
    send(FUNC_PROC, 0, CP_W'("M"));
    apply_cfg('{0, 1, 0, 4'hF, 4'hF, 9'd0, 9'd0, CMAP_LOWER});
    send(FUNC_PROC, 0, CP_W'("x"));
    send(FUNC_PROC, 0, CP_W'("7"));
    send(FUNC_PROC, 0, CP_W'("#"));
    apply_cfg('{0, 0, 0, 4'hF, '0, 9'd0, 9'd3, CMAP_UPPER});
    send(FUNC_PROC, 0, CP_W'("a"));
    send(FUNC_PROC, 0, CP_W'("z"));
    send(FUNC_PROC, 0, CP_W'("{"));
    apply_cfg('{0, 0, 0, 4'hF, '0, 9'd0, 9'd3, CMAP_LOWER});
    send(FUNC_PROC, 0, CP_W'("A"));
    apply_cfg('{0, 0, 0, 4'hF, '0, 9'd0, 9'd3, 2'd3});
    send(FUNC_PROC, 0, CP_W'("Q"));

    for (int p = 0; items_sent < 1750; p++) begin
      c = random_cfg();
      apply_cfg(c);
      no_idle = (p >= 10 && p < 13);
      for (int k = 0; k < 40; k++) begin
        int r;
        r = $urandom_range(0, 99);
        if (p == 5 && k == 20) drain(1'b0);
        if (r < 6) send(FUNC_RESTART, $urandom_range(0, 255), CP_W'($urandom));
        else if (r < 12) send(FUNC_LOAD1, $urandom_range(0, 15), pick_entry());
        else if (r < 18) send(FUNC_LOAD2, $urandom_range(0, 15), pick_entry());
        else send(FUNC_PROC, $urandom_range(0, 255), pick_codepoint());
      end
    end
    no_idle = 1'b0;
    drain(1'b1);

    $display("Ran %0d items over %0d configurations, %0d output beats checked.",
             items_sent, cfg_phases, beats_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
